@@ hdl/lzwc_pkg.sv @@
// ----------------------------------------------------------------------------
// LZW stream compressor package
// Shared widths, dictionary entry layout and controller/datapath interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package lzwc_pkg;

    localparam int SYM_W         = 7;
    localparam int CODE_W        = 12;
    localparam int ALPHABET_SIZE = 128;
    localparam int DICT_ENTRIES  = 4096;
    localparam int SLOT_W        = 12;
    localparam int NFC_W         = 13;
    localparam int HASH_SHIFT    = 5;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 16;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] prefix;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic accept;
        logic start_prefix;
        logic probe_start;
        logic probe_next;
        logic hit_take;
        logic miss_take;
        logic insert;
        logic out_load_emit;
        logic out_load_final;
        logic msg_end;
        logic clear_wr;
    } cmd_t;

    typedef struct packed {
        logic prefix_valid;
        logic entry_valid;
        logic entry_match;
        logic fin;
        logic out_free;
        logic dict_full;
        logic clear_done;
    } sts_t;

endpackage

`default_nettype wire

@@ hdl/lzwc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwc_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hdl/lzwc_datapath.sv @@
// ----------------------------------------------------------------------------
// LZW datapath
// Prefix and code registers, hashed dictionary with linear probing, output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwc_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire lzwc_pkg::cmd_t                 cmd,
    output lzwc_pkg::sts_t                      sts,
    input  wire logic [lzwc_pkg::SYM_W-1:0]     in_symbol,
    input  wire logic                           in_final,
    output logic      [lzwc_pkg::CODE_W-1:0]    out_code,
    output logic                                out_last,
    output logic                                out_valid,
    input  wire logic                           out_ready
);

    logic [lzwc_pkg::SYM_W-1:0]  sym_reg;
    logic                        fin_reg;
    logic [lzwc_pkg::CODE_W-1:0] prefix_reg;
    logic                        prefix_valid_reg;
    logic [lzwc_pkg::NFC_W-1:0]  nfc_reg;
    logic [lzwc_pkg::SLOT_W-1:0] slot_reg;
    logic [lzwc_pkg::CODE_W-1:0] emit_reg;
    logic [lzwc_pkg::SLOT_W-1:0] clr_reg;
    logic [lzwc_pkg::CODE_W-1:0] ocode_reg;
    logic                        olast_reg;
    logic                        ofull_reg;

    logic [lzwc_pkg::SLOT_W-1:0]  hash;
    logic [lzwc_pkg::ENTRY_W-1:0] rd_raw;
    lzwc_pkg::entry_t             rd_ent;
    lzwc_pkg::entry_t             wr_ent;
    logic                         we;
    logic [lzwc_pkg::SLOT_W-1:0]  waddr;
    logic                         full;

    assign hash = prefix_reg[lzwc_pkg::SLOT_W-1:0]
                ^ lzwc_pkg::SLOT_W'({in_symbol, lzwc_pkg::HASH_SHIFT'(0)});
    assign rd_ent = lzwc_pkg::entry_t'(rd_raw);
    assign full = (nfc_reg == lzwc_pkg::NFC_W'(lzwc_pkg::DICT_ENTRIES));

    always_comb
    begin
        wr_ent = '0;
        waddr  = clr_reg;
        we     = 1'b0;
        if (cmd.clear_wr)
        begin
            we = 1'b1;
        end
        else if (cmd.insert)
        begin
            we            = 1'b1;
            waddr         = slot_reg;
            wr_ent.valid  = 1'b1;
            wr_ent.prefix = prefix_reg;
            wr_ent.symbol = sym_reg;
            wr_ent.code   = nfc_reg[lzwc_pkg::CODE_W-1:0];
        end
    end

    lzwc_ram #(
        .WIDTH (lzwc_pkg::ENTRY_W),
        .DEPTH (lzwc_pkg::DICT_ENTRIES)
    ) u_dict (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (lzwc_pkg::ENTRY_W'(wr_ent)),
        .raddr (slot_reg),
        .rdata (rd_raw)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_valid_reg <= 1'b0;
            prefix_reg       <= '0;
            nfc_reg          <= lzwc_pkg::NFC_W'(lzwc_pkg::ALPHABET_SIZE);
            clr_reg          <= '0;
            ofull_reg        <= 1'b0;
        end
        else
        begin
            if (cmd.start_prefix)
            begin
                prefix_reg       <= lzwc_pkg::CODE_W'(in_symbol);
                prefix_valid_reg <= 1'b1;
            end
            if (cmd.hit_take)
            begin
                prefix_reg <= rd_ent.code;
            end
            if (cmd.miss_take)
            begin
                prefix_reg <= lzwc_pkg::CODE_W'(sym_reg);
            end
            if (cmd.insert)
            begin
                nfc_reg <= nfc_reg + 1'b1;
            end
            if (cmd.msg_end)
            begin
                prefix_valid_reg <= 1'b0;
                prefix_reg       <= '0;
                nfc_reg          <= lzwc_pkg::NFC_W'(lzwc_pkg::ALPHABET_SIZE);
            end
            if (cmd.clear_wr)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.out_load_emit || cmd.out_load_final)
            begin
                ofull_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ofull_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sym_reg <= in_symbol;
            fin_reg <= in_final;
        end
        if (cmd.probe_start)
        begin
            slot_reg <= hash;
        end
        else if (cmd.probe_next)
        begin
            slot_reg <= slot_reg + 1'b1;
        end
        if (cmd.miss_take)
        begin
            emit_reg <= prefix_reg;
        end
        if (cmd.out_load_emit)
        begin
            ocode_reg <= emit_reg;
            olast_reg <= 1'b0;
        end
        else if (cmd.out_load_final)
        begin
            ocode_reg <= prefix_reg;
            olast_reg <= 1'b1;
        end
    end

    always_comb
    begin
        sts.prefix_valid = prefix_valid_reg;
        sts.entry_valid  = rd_ent.valid;
        sts.entry_match  = (rd_ent.prefix == prefix_reg) && (rd_ent.symbol == sym_reg);
        sts.fin          = fin_reg;
        sts.out_free     = !ofull_reg || out_ready;
        sts.dict_full    = full;
        sts.clear_done   = (clr_reg == '1);
    end

    assign out_code  = ocode_reg;
    assign out_last  = olast_reg;
    assign out_valid = ofull_reg;

endmodule

`default_nettype wire

@@ hdl/lzwc_ctrl.sv @@
// ----------------------------------------------------------------------------
// LZW controller
// Sequences accept, dictionary probe, insert, code output and clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwc_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire lzwc_pkg::sts_t sts,
    output lzwc_pkg::cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WAIT,
        ST_CMP,
        ST_EMIT,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (!sts.prefix_valid)
                    begin
                        cmd.start_prefix = 1'b1;
                        state_next       = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_WAIT:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                priority if (sts.entry_valid && sts.entry_match)
                begin
                    cmd.hit_take = 1'b1;
                    state_next   = ST_FIN;
                end
                else if (sts.entry_valid)
                begin
                    cmd.probe_next = 1'b1;
                    state_next     = ST_WAIT;
                end
                else
                begin
                    cmd.insert    = !sts.dict_full;
                    cmd.miss_take = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load_emit = 1'b1;
                    state_next        = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!sts.fin)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.out_load_final = 1'b1;
                    cmd.msg_end        = 1'b1;
                    state_next         = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        if (cmd.accept)
        begin
            cmd.probe_start = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/lzw_stream_compressor.sv @@
// ----------------------------------------------------------------------------
// LZW stream compressor
// Turns 7-bit symbols into 12-bit LZW codes over a per-message dictionary.
// ----------------------------------------------------------------------------
// The slave channel takes one symbol per request, tlast marking the last
// symbol of a message. The master channel gives LZW codes, tlast marking the
// final code of a message. A symbol gives zero, one or two codes.
// The dictionary is a 4096-entry hash table with linear probing in one RAM;
// each probe sets the slot address, waits in ST_WAIT for the registered read
// and compares in ST_CMP. A symbol that starts a message goes from ST_IDLE
// to ST_FIN; any other probes, then passes ST_EMIT when a code is loaded.
// After reset and after every final code a clearing pass writes all 4096
// entries, one a cycle; s_axis_tready stays low throughout the pass.
// A single output register holds the code; when the receiver stalls the
// block finishes the current symbol up to that register and then waits,
// holding tready low until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_stream_compressor (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [6:0] symbol, [7] zero
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,  // [11:0] code, [15:12] zero
    output logic             m_axis_tlast
);

    lzwc_pkg::cmd_t              cmd;
    lzwc_pkg::sts_t              sts;
    logic [lzwc_pkg::CODE_W-1:0] code;

    lzwc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lzwc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_symbol (s_axis_tdata[lzwc_pkg::SYM_W-1:0]),
        .in_final  (s_axis_tlast),
        .out_code  (code),
        .out_last  (m_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tdata = lzwc_pkg::OUT_TDATA_W'(code);

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load_emit || cmd.out_load_final) |-> sts.out_free)
        else $error("output register loaded while occupied");

    a_insert_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> (!sts.dict_full && !sts.entry_valid))
        else $error("insert into occupied slot or full dictionary");

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !cmd.clear_wr)
        else $error("request accepted during clearing pass");

    a_final_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.msg_end |=> !sts.prefix_valid)
        else $error("prefix still valid after final code");

endmodule

`default_nettype wire

@@ tb/sv/lzw_stream_compressor_test.sv @@
// ----------------------------------------------------------------------------
// LZW stream compressor testbench
// Streams symbol messages into the compressor and scores every emitted code
// against an LZW encoder held in the bench, under random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_stream_compressor_test;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN_WAIT  = 64;

    typedef struct {
        logic [lzwc_pkg::CODE_W-1:0] code;
        logic                        last;
    } code_item_t;

    logic                             clk;
    logic                             rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [lzwc_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic                             s_axis_tlast;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [lzwc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             m_axis_tlast;

    code_item_t                  pending_codes[$];
    int                          phrase_codes[bit [lzwc_pkg::CODE_W+lzwc_pkg::SYM_W-1:0]];
    int                          next_code;
    logic [lzwc_pkg::CODE_W-1:0] cur_prefix;
    bit                          cur_prefix_valid;

    int errors;
    int cycles;
    int symbols_sent;
    int codes_seen;
    int messages_sent;
    int idle_pct;
    int stall_pct;
    int hold_left;

    lzw_stream_compressor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [6:0] symbol, [7] zero
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [11:0] code, [15:12] zero
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else
        begin
            m_axis_tready <= rst_n && ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        code_item_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            codes_seen++;
            if (pending_codes.size() == 0)
            begin
                errors++;
                $error("unexpected code: got code %0d last %0b",
                       m_axis_tdata[lzwc_pkg::CODE_W-1:0], m_axis_tlast);
            end
            else
            begin
                want = pending_codes.pop_front();
                if (m_axis_tdata[lzwc_pkg::CODE_W-1:0] !== want.code)
                begin
                    errors++;
                    $error("code: expected %0d, got %0d", want.code,
                           m_axis_tdata[lzwc_pkg::CODE_W-1:0]);
                end
                if (m_axis_tlast !== want.last)
                begin
                    errors++;
                    $error("last_code: expected %0b, got %0b", want.last, m_axis_tlast);
                end
            end
        end
    end

    function automatic void reset_dictionary();
        phrase_codes.delete();
        next_code = lzwc_pkg::ALPHABET_SIZE;
    endfunction

    function automatic void push_code(logic [lzwc_pkg::CODE_W-1:0] code, logic last);
        code_item_t item;
        item.code = code;
        item.last = last;
        pending_codes.push_back(item);
    endfunction

    function automatic void lzw_encode_symbol(logic [lzwc_pkg::SYM_W-1:0] sym, logic fin);
        bit [lzwc_pkg::CODE_W+lzwc_pkg::SYM_W-1:0] key;
        key = {cur_prefix, sym};
        if (!cur_prefix_valid)
        begin
            cur_prefix       = lzwc_pkg::CODE_W'(sym);
            cur_prefix_valid = 1'b1;
        end
        else if (phrase_codes.exists(key))
        begin
            cur_prefix = lzwc_pkg::CODE_W'(phrase_codes[key]);
        end
        else
        begin
            push_code(cur_prefix, 1'b0);
            if (next_code < lzwc_pkg::DICT_ENTRIES)
            begin
                phrase_codes[key] = next_code;
                next_code++;
            end
            cur_prefix = lzwc_pkg::CODE_W'(sym);
        end
        if (fin)
        begin
            push_code(cur_prefix, 1'b1);
            cur_prefix_valid = 1'b0;
            cur_prefix       = '0;
            reset_dictionary();
        end
    endfunction

    task automatic send_symbol(logic [lzwc_pkg::SYM_W-1:0] sym, logic fin);
        if ($urandom_range(99) < idle_pct)
        begin
            repeat ($urandom_range(1, 6))
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
            end
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, sym};
        s_axis_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_axis_tready);
        lzw_encode_symbol(sym, fin);
        symbols_sent++;
        if (fin)
            messages_sent++;
    endtask

    task automatic wait_drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic send_message(int len, int span);
        int base;
        base = $urandom_range(0, 127 - span);
        for (int i = 0; i < len; i++)
            send_symbol(lzwc_pkg::SYM_W'(base + $urandom_range(0, span)), i == len - 1);
    endtask

    task automatic test_directed();
        logic [lzwc_pkg::SYM_W-1:0] pattern[$];
        idle_pct  = 0;
        stall_pct = 0;
        send_symbol(7'd0, 1'b1);
        send_symbol(7'd127, 1'b1);
        pattern = '{7'h55, 7'h2A, 7'h55, 7'h2A, 7'h55, 7'h2A, 7'h55, 7'h2A};
        foreach (pattern[i])
            send_symbol(pattern[i], 1'b0);
        send_symbol(7'h55, 1'b1);
        pattern = '{7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd0, 7'd0, 7'd0};
        foreach (pattern[i])
            send_symbol(pattern[i], i == pattern.size() - 1);
        wait_drain();
    endtask

    task automatic test_random_phase(int idle, int stall, int count);
        int sent;
        int len;
        idle_pct  = idle;
        stall_pct = stall;
        sent      = 0;
        while (sent < count)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 90);
            send_message(len, ($urandom_range(0, 2) == 0) ? 127 : $urandom_range(1, 5));
            sent += len;
        end
        wait_drain();
    endtask

    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = 400;
        send_message(60, 2);
        wait_drain();
        send_message(40, 127);
        wait_drain();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        errors        = 0;
        cycles        = 0;
        symbols_sent  = 0;
        codes_seen    = 0;
        messages_sent = 0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_left     = 0;
        cur_prefix       = '0;
        cur_prefix_valid = 1'b0;
        reset_dictionary();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_backpressure();
        test_random_phase(0, 0, 300);
        test_random_phase(71, 0, 300);
        test_random_phase(0, 71, 300);
        test_random_phase(14, 14, 300);

        $display("covered %0d symbols in %0d messages, %0d codes checked",
                 symbols_sent, messages_sent, codes_seen);
        $display("incl. single-symbol messages, long output hold-off and idling on both sides");
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
